### sv/history_window_majority_vote_top_macros.svh
// Assertion macros for the history window majority vote checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef HISTORY_WINDOW_MAJORITY_VOTE_TOP_MACROS_SVH
`define HISTORY_WINDOW_MAJORITY_VOTE_TOP_MACROS_SVH

// same-cycle implication
`define HWMV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hwmv assertion failed");

// next-cycle implication
`define HWMV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hwmv assertion failed");

`endif

### sv/hwmv_pkg.sv
// Shared constants and types for the history window majority vote block.
// No dependencies.
`default_nettype none

package hwmv_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int PATTERN_BITS  = 10;
  localparam int PAT_IN_W      = 10;
  localparam int OUT_W         = 11;
  localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [OUT_W-1:0] EMPTY_CODE = '1;

  typedef struct packed {
    logic                    en;
    logic [PATTERN_BITS-1:0] value;
  } wr_t;

  typedef struct packed {
    logic                    vld;
    logic [PATTERN_BITS-1:0] value;
  } rd_t;

endpackage

`default_nettype wire

### sv/hwmv_ring.sv
// History ring: slot values, valid bits, write cursor, one read port.
// Also tracks the newest stored entry. Depends on hwmv_pkg.
`default_nettype none

module hwmv_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hwmv_pkg::wr_t                 wr_i,
  input  logic [hwmv_pkg::IDX_W-1:0]    rd_addr_i,
  output hwmv_pkg::rd_t                 rd_o,
  output hwmv_pkg::rd_t                 newest_o
);
  import hwmv_pkg::*;

  logic [PATTERN_BITS-1:0]  value_q [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_q;
  logic [IDX_W-1:0]         cursor_q;
  logic                     newest_vld_q;
  logic [PATTERN_BITS-1:0]  newest_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      cursor_q     <= '0;
      newest_vld_q <= 1'b0;
    end else if (wr_i.en) begin
      valid_q[cursor_q] <= 1'b1;
      newest_vld_q      <= 1'b1;
      cursor_q          <= (cursor_q == LAST_IDX) ? '0 : cursor_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      value_q[cursor_q] <= wr_i.value;
      newest_value_q    <= wr_i.value;
    end
  end

  assign rd_o.vld       = valid_q[rd_addr_i];
  assign rd_o.value     = value_q[rd_addr_i];
  assign newest_o.vld   = newest_vld_q;
  assign newest_o.value = newest_value_q;

endmodule

`default_nettype wire

### sv/history_window_majority_vote_top.sv
// History window majority vote: the input channel carries fire, learn and
// pattern_id; the output channel carries likely_pattern and newest_entry.
// When fire and learn are both set the pattern is stored at the write cursor.
// Every transaction yields one result: the most frequent stored value (ties to
// the smallest, all ones = -1 when empty) and the newest stored value.
// One equality comparator is shared: for each occupied slot the sequencer
// latches it as candidate in S_LOAD and walks all slots in S_COUNT counting
// matches; an empty slot is skipped in S_LOAD. in_ready_o is low from the
// input transaction until the result is loaded.
// The result sits in an output register; the next input is taken once the
// result is loaded there, so a stalled receiver delays only the load of the
// following result. Reset empties the ring, zeroes the cursor and drops
// out_valid_o. Depends on hwmv_pkg and hwmv_ring.
`default_nettype none

module history_window_majority_vote_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  fire_i,
  input  logic                                  learn_i,
  input  logic [hwmv_pkg::PAT_IN_W-1:0]         pattern_id_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [hwmv_pkg::OUT_W-1:0]     likely_pattern_o,
  output logic signed [hwmv_pkg::OUT_W-1:0]     newest_entry_o
);
  import hwmv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOAD  = 4'b0010,
    S_COUNT = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        i_q, i_d;
  logic [IDX_W-1:0]        j_q, j_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [PATTERN_BITS-1:0] cand_q, cand_d;
  logic                    found_q, found_d;
  logic [PATTERN_BITS-1:0] best_q, best_d;
  logic [CNT_W-1:0]        best_cnt_q, best_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_W-1:0]        likely_q, likely_d;
  logic [OUT_W-1:0]        newest_q, newest_d;

  wr_t              wr;
  rd_t              rd;
  rd_t              newest;
  logic [IDX_W-1:0] rd_addr;
  logic             in_fire;
  logic             match;
  logic [CNT_W-1:0] cnt_sum;
  logic             take;
  logic             out_free;

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign wr.en    = in_fire && fire_i && learn_i;
  assign wr.value = pattern_id_i[PATTERN_BITS-1:0];
  assign rd_addr  = (state_q == S_COUNT) ? j_q : i_q;

  hwmv_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_o      (rd),
    .newest_o  (newest)
  );

  assign match    = rd.vld && (rd.value == cand_q);
  assign cnt_sum  = cnt_q + CNT_W'(match);
  assign take     = !found_q || (cnt_sum > best_cnt_q) ||
                    ((cnt_sum == best_cnt_q) && (cand_q < best_q));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    cand_d      = cand_q;
    found_d     = found_q;
    best_d      = best_q;
    best_cnt_d  = best_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    likely_d    = likely_q;
    newest_d    = newest_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          i_d     = '0;
          found_d = 1'b0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (rd.vld) begin
          cand_d  = rd.value;
          j_d     = '0;
          cnt_d   = '0;
          state_d = S_COUNT;
        end else if (i_q == LAST_IDX) begin
          state_d = S_FIN;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      S_COUNT: begin
        cnt_d = cnt_sum;
        if (j_q == LAST_IDX) begin
          if (take) begin
            found_d    = 1'b1;
            best_d     = cand_q;
            best_cnt_d = cnt_sum;
          end
          if (i_q == LAST_IDX) begin
            state_d = S_FIN;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_LOAD;
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          likely_d    = found_q ?
                        {{(OUT_W-PATTERN_BITS){1'b0}}, best_q} : EMPTY_CODE;
          newest_d    = newest.vld ?
                        {{(OUT_W-PATTERN_BITS){1'b0}}, newest.value} : EMPTY_CODE;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      i_q         <= i_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    cand_q     <= cand_d;
    best_q     <= best_d;
    best_cnt_q <= best_cnt_d;
    likely_q   <= likely_d;
    newest_q   <= newest_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign likely_pattern_o = likely_q;
  assign newest_entry_o   = newest_q;

endmodule

`default_nettype wire

### sv/hwmv_checker.sv
// Port-level checks for history_window_majority_vote_top, bound to the top.
// Depends on hwmv_pkg and history_window_majority_vote_top_macros.svh.
`default_nettype none

`include "history_window_majority_vote_top_macros.svh"

module hwmv_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic signed [hwmv_pkg::OUT_W-1:0] likely_pattern_o,
  input wire logic signed [hwmv_pkg::OUT_W-1:0] newest_entry_o
);
  import hwmv_pkg::*;

  `HWMV_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(likely_pattern_o) && $stable(newest_entry_o))

  `HWMV_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o)

  `HWMV_ASSERT_IMPL(a_likely_range, out_valid_o,
    (likely_pattern_o[OUT_W-1] == 1'b0) || (likely_pattern_o == EMPTY_CODE))

  `HWMV_ASSERT_IMPL(a_newest_range, out_valid_o,
    (newest_entry_o[OUT_W-1] == 1'b0) || (newest_entry_o == EMPTY_CODE))

endmodule

bind history_window_majority_vote_top hwmv_checker u_hwmv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .likely_pattern_o (likely_pattern_o),
  .newest_entry_o   (newest_entry_o)
);

`default_nettype wire
